// ----- rtl/assert_macros.svh -----
// ---------------------------------------------------------------------------
// Assertion macros
// Short forms for the concurrent checks used in the RTL.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ASSERT_HOLDS(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ----- rtl/imuc_pkg.sv -----
// ---------------------------------------------------------------------------
// IMU attitude filter package
// Item types, register indexes, reset values and shared arithmetic helpers.
// ---------------------------------------------------------------------------
package imuc_pkg;

   // Fraction bits of the arctangent table, in degrees.
   localparam int TAB_FRAC = 24;
   // Gyro counts per degree per second.
   localparam int GYRO_SCALE = 131;
   // Degrees per radian with 24 fraction bits.
   localparam logic [63:0] DEG_PER_RAD_Q24 = 64'd961263669;

   // Blend weight of exactly one.
   localparam logic [16:0] WEIGHT_ONE = 17'd65536;
   localparam logic [16:0] BLEND_WEIGHT_RESET = 17'd64225;
   localparam logic [23:0] TIME_STEP_RESET = 24'd335544;

   // Register indexes.
   localparam int CSR_INDEX_W = 8;
   localparam logic [CSR_INDEX_W-1:0] CSR_BLEND_WEIGHT = 8'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_TIME_STEP = 8'd1;

   // One set of raw IMU samples.
   typedef struct packed {
      logic signed [15:0] accel_x;
      logic signed [15:0] accel_y;
      logic signed [15:0] accel_z;
      logic signed [15:0] gyro_x;
      logic signed [15:0] gyro_y;
      logic signed [15:0] gyro_z;
   } imu_sample_type;

   // One attitude estimate, degrees in signed fixed point.
   typedef struct packed {
      logic signed [31:0] roll_out;
      logic signed [31:0] pitch_out;
      logic signed [31:0] yaw_out;
   } attitude_type;

   // Arctangent of 2^-i in degrees with 24 fraction bits.
   function automatic logic [31:0] atan_entry(input logic [4:0] idx);
      logic [63:0] v;
      v = '0;
      unique case (idx)
         5'd0:  v = 64'd754974720;
         5'd1:  v = 64'd445687602;
         5'd2:  v = 64'd235489088;
         5'd3:  v = 64'd119537938;
         5'd4:  v = 64'd60000934;
         5'd5:  v = 64'd30029717;
         5'd6:  v = 64'd15018523;
         5'd7:  v = 64'd7509720;
         5'd8:  v = 64'd3754917;
         5'd9:  v = 64'd1877466;
         5'd10: v = 64'd938734;
         5'd11: v = 64'd469367;
         5'd12: v = 64'd234684;
         5'd13: v = 64'd117342;
         5'd14: v = 64'd58671;
         5'd15: v = 64'd29335;
         default: v = (DEG_PER_RAD_Q24 + (64'd1 << (idx - 5'd1))) >> idx;
      endcase
      return v[31:0];
   endfunction

   // Saturate to the signed 32-bit range.
   function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
      logic signed [31:0] r;
      r = v[31:0];
      if (v > 64'sd2147483647) begin
         r = 32'sh7fffffff;
      end else if (v < -64'sd2147483648) begin
         r = 32'sh80000000;
      end
      return r;
   endfunction

endpackage

// ----- rtl/imu_complementary_attitude_filter_top.sv -----
// ---------------------------------------------------------------------------
// IMU complementary attitude filter
// Blends accelerometer roll and pitch with gyro-integrated angles and
// integrates a wrapped yaw, all in signed fixed-point degrees.
//
//   Port group   Direction   Moves
//   req_         in          one item of six raw IMU samples
//   rsp_         out         one item of roll, pitch and yaw estimates
//   csr_         in          register writes (blend weight, time step)
//
// An item is taken only from idle: the next acceptance waits until the
// angle units finish their square root and CORDIC and the rate units their
// 40-bit serial division, the serial blend multiply has run and the result
// has been handed to the output register. Reset is synchronous and needs no
// clearing pass. A stalled result waits in the output register while the next
// item is taken.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module imu_complementary_attitude_filter_top #(
   parameter int CORDIC_STEPS    = 16,
   parameter int ANGLE_FRAC_BITS = 16
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_stall,
   input  imuc_pkg::imu_sample_type   req_data,
   output logic                       rsp_valid,
   input  logic                       rsp_stall,
   output imuc_pkg::attitude_type     rsp_data,
   input  logic                       csr_write,
   input  logic [imuc_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [23:0]                csr_wdata
);
   import imuc_pkg::*;

   localparam int EW = 37;
   localparam int AW = 56;
   localparam logic signed [EW-1:0] YAW_HALF = EW'(180) << ANGLE_FRAC_BITS;
   localparam logic signed [EW-1:0] YAW_FULL = EW'(360) << ANGLE_FRAC_BITS;
   localparam logic [4:0] LAST_WBIT = 5'd16;

   typedef enum logic [1:0] {ST_IDLE, ST_RUN, ST_BLEND, ST_FINISH} state_type;

   state_type             state_ff, state_in;
   imu_sample_type        in_ff, in_in;
   logic                  start_ff, start_in;
   logic [16:0]           weight_ff, weight_in;
   logic [23:0]           tstep_ff, tstep_in;
   logic signed [31:0]    roll_state_ff, roll_state_in;
   logic signed [31:0]    pitch_state_ff, pitch_state_in;
   logic signed [31:0]    yaw_state_ff, yaw_state_in;
   logic signed [AW-1:0]  racc_ff, racc_in, pacc_ff, pacc_in;
   logic signed [AW-1:0]  rdiff_ff, rdiff_in, pdiff_ff, pdiff_in;
   logic [16:0]           wt_ff, wt_in;
   logic [4:0]            bcnt_ff, bcnt_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   attitude_type          rsp_data_ff, rsp_data_in;

   logic signed [16:0]    roll_num, pitch_num;
   logic                  roll_done, pitch_done, gx_done, gy_done, gz_done;
   logic signed [32:0]    roll_angle, pitch_angle;
   logic signed [33:0]    dx, dy, dz;
   logic                  all_done;
   logic [16:0]           weight_eff;
   logic signed [EW-1:0]  roll_e, pitch_e, yaw_sum, yaw_wrap1, yaw_wrap2;
   logic                  out_free;

   // Accelerometer angles for roll and pitch.
   assign roll_num  = 17'(in_ff.accel_y);
   assign pitch_num = -(17'(in_ff.accel_x));

   imuc_angle #(.CORDIC_STEPS(CORDIC_STEPS), .ANGLE_FRAC_BITS(ANGLE_FRAC_BITS)) u_roll (
      .clock(clock), .reset(reset), .start(start_ff), .num(roll_num),
      .side_a(in_ff.accel_x), .side_b(in_ff.accel_z),
      .done(roll_done), .angle(roll_angle)
   );

   imuc_angle #(.CORDIC_STEPS(CORDIC_STEPS), .ANGLE_FRAC_BITS(ANGLE_FRAC_BITS)) u_pitch (
      .clock(clock), .reset(reset), .start(start_ff), .num(pitch_num),
      .side_a(in_ff.accel_y), .side_b(in_ff.accel_z),
      .done(pitch_done), .angle(pitch_angle)
   );

   // Gyro increments, one unit per axis.
   imuc_rate #(.ANGLE_FRAC_BITS(ANGLE_FRAC_BITS)) u_rate_x (
      .clock(clock), .reset(reset), .start(start_ff), .raw(in_ff.gyro_x),
      .step(tstep_ff), .done(gx_done), .delta(dx)
   );

   imuc_rate #(.ANGLE_FRAC_BITS(ANGLE_FRAC_BITS)) u_rate_y (
      .clock(clock), .reset(reset), .start(start_ff), .raw(in_ff.gyro_y),
      .step(tstep_ff), .done(gy_done), .delta(dy)
   );

   imuc_rate #(.ANGLE_FRAC_BITS(ANGLE_FRAC_BITS)) u_rate_z (
      .clock(clock), .reset(reset), .start(start_ff), .raw(in_ff.gyro_z),
      .step(tstep_ff), .done(gz_done), .delta(dz)
   );

   // Gyro-propagated estimates, yaw wrap and the clamped weight.
   always_comb begin
      all_done   = roll_done && pitch_done && gx_done && gy_done && gz_done;
      weight_eff = (weight_ff > WEIGHT_ONE) ? WEIGHT_ONE : weight_ff;
      roll_e     = EW'(roll_state_ff) + EW'(dx);
      pitch_e    = EW'(pitch_state_ff) + EW'(dy);
      yaw_sum    = EW'(yaw_state_ff) + EW'(dz);
      yaw_wrap1  = (yaw_sum > YAW_HALF) ? yaw_sum - YAW_FULL : yaw_sum;
      yaw_wrap2  = (yaw_wrap1 < -YAW_HALF) ? yaw_wrap1 + YAW_FULL : yaw_wrap1;
      out_free   = !rsp_valid_ff || !rsp_stall;
   end

   // Control sequence, serial blend and output register.
   always_comb begin
      state_in       = state_ff;
      in_in          = in_ff;
      start_in       = 1'b0;
      weight_in      = weight_ff;
      tstep_in       = tstep_ff;
      roll_state_in  = roll_state_ff;
      pitch_state_in = pitch_state_ff;
      yaw_state_in   = yaw_state_ff;
      racc_in        = racc_ff;
      pacc_in        = pacc_ff;
      rdiff_in       = rdiff_ff;
      pdiff_in       = pdiff_ff;
      wt_in          = wt_ff;
      bcnt_in        = bcnt_ff;
      rsp_valid_in   = rsp_valid_ff;
      rsp_data_in    = rsp_data_ff;

      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end

      if (csr_write) begin
         if (csr_index == CSR_BLEND_WEIGHT) begin
            weight_in = csr_wdata[16:0];
         end else if (csr_index == CSR_TIME_STEP) begin
            tstep_in = csr_wdata;
         end
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               in_in    = req_data;
               start_in = 1'b1;
               state_in = ST_RUN;
            end
         end
         ST_RUN: begin
            // sum = (acc << 16) + weight * (estimate + delta - acc) + half
            if (!start_ff && all_done) begin
               racc_in  = (AW'(roll_angle) <<< 16) + AW'(32768);
               pacc_in  = (AW'(pitch_angle) <<< 16) + AW'(32768);
               rdiff_in = AW'(roll_e - EW'(roll_angle));
               pdiff_in = AW'(pitch_e - EW'(pitch_angle));
               wt_in    = weight_eff;
               bcnt_in  = '0;
               state_in = ST_BLEND;
            end
         end
         ST_BLEND: begin
            if (wt_ff[0]) begin
               racc_in = racc_ff + rdiff_ff;
               pacc_in = pacc_ff + pdiff_ff;
            end
            rdiff_in = rdiff_ff <<< 1;
            pdiff_in = pdiff_ff <<< 1;
            wt_in    = wt_ff >> 1;
            bcnt_in  = bcnt_ff + 5'd1;
            if (bcnt_ff == LAST_WBIT) begin
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            if (out_free) begin
               roll_state_in         = sat32(64'(racc_ff >>> 16));
               pitch_state_in        = sat32(64'(pacc_ff >>> 16));
               yaw_state_in          = sat32(64'(yaw_wrap2));
               rsp_data_in.roll_out  = roll_state_in;
               rsp_data_in.pitch_out = pitch_state_in;
               rsp_data_in.yaw_out   = yaw_state_in;
               rsp_valid_in          = 1'b1;
               state_in              = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         start_ff       <= 1'b0;
         weight_ff      <= BLEND_WEIGHT_RESET;
         tstep_ff       <= TIME_STEP_RESET;
         roll_state_ff  <= '0;
         pitch_state_ff <= '0;
         yaw_state_ff   <= '0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff       <= state_in;
         start_ff       <= start_in;
         weight_ff      <= weight_in;
         tstep_ff       <= tstep_in;
         roll_state_ff  <= roll_state_in;
         pitch_state_ff <= pitch_state_in;
         yaw_state_ff   <= yaw_state_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
      in_ff       <= in_in;
      racc_ff     <= racc_in;
      pacc_ff     <= pacc_in;
      rdiff_ff    <= rdiff_in;
      pdiff_ff    <= pdiff_in;
      wt_ff       <= wt_in;
      bcnt_ff     <= bcnt_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // A start must clear every unit's finished flag.
   `ASSERT_NEXT(a_start_clears_done, clock, reset, start_ff, !all_done, "units still done after start")
   // The blend only runs on finished unit results.
   `ASSERT_HOLDS(a_blend_needs_done, clock, reset, state_ff == ST_BLEND, all_done, "blend without results")
   // A new result appears only out of the finishing step.
   `ASSERT_HOLDS(a_rsp_from_finish, clock, reset, $rose(rsp_valid_ff), $past(state_ff) == ST_FINISH, "result outside finish")

endmodule

// ----- rtl/imuc_angle.sv -----
// ---------------------------------------------------------------------------
// Accelerometer angle unit
// Computes atan2(num, sqrt(a^2 + b^2)) in degrees: a two-bit-per-cycle
// square root followed by an iterative vectoring CORDIC.
// ---------------------------------------------------------------------------
module imuc_angle #(
   parameter int CORDIC_STEPS    = 16,
   parameter int ANGLE_FRAC_BITS = 16
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   input  logic signed [16:0] num,
   input  logic signed [15:0] side_a,
   input  logic signed [15:0] side_b,
   output logic               done,
   output logic signed [32:0] angle
);
   import imuc_pkg::*;

   localparam int XW    = 28;
   localparam int ZW    = 33;
   localparam int ROOTW = 24;
   localparam int RADW  = 48;
   localparam int REMW  = 26;
   localparam int CW    = (CORDIC_STEPS > 1) ? $clog2(CORDIC_STEPS) : 1;
   localparam int SHIFT = TAB_FRAC - ANGLE_FRAC_BITS;
   localparam logic signed [ZW-1:0] ROUND_HALF =
      (SHIFT > 0) ? (ZW'(1) << ((SHIFT > 0) ? SHIFT - 1 : 0)) : '0;
   localparam logic [CW-1:0] LAST_STEP = CW'(CORDIC_STEPS - 1);
   localparam logic [4:0]    LAST_ROOT = 5'(ROOTW - 1);

   typedef enum logic [2:0] {
      ST_IDLE, ST_SQA, ST_SQB, ST_ROOT, ST_ROT, ST_ROUND
   } state_type;

   state_type              state_ff, state_in;
   logic [31:0]            sq_ff, sq_in;
   logic [RADW-1:0]        rad_ff, rad_in;
   logic [REMW-1:0]        rem_ff, rem_in;
   logic [ROOTW-1:0]       root_ff, root_in;
   logic [4:0]             rcnt_ff, rcnt_in;
   logic signed [XW-1:0]   x_ff, x_in, y_ff, y_in;
   logic signed [ZW-1:0]   z_ff, z_in;
   logic [CW-1:0]          step_ff, step_in;
   logic                   zero_ff, zero_in;
   logic                   done_ff, done_in;
   logic signed [ZW-1:0]   angle_ff, angle_in;

   logic signed [31:0]     prod;
   logic [REMW+1:0]        rem_cat, trial, rem_diff;
   logic                   fits;
   logic [ROOTW-1:0]       root_next;
   logic signed [XW-1:0]   xs, ys;
   logic signed [ZW-1:0]   ent, z_round;

   // Shared squarer, then the square root digit and the CORDIC step.
   always_comb begin
      prod      = (state_ff == ST_SQA) ? side_a * side_a : side_b * side_b;
      rem_cat   = {rem_ff, rad_ff[RADW-1 -: 2]};
      trial     = {2'b00, root_ff, 2'b01};
      rem_diff  = rem_cat - trial;
      fits      = (rem_cat >= trial);
      root_next = {root_ff[ROOTW-2:0], fits};
      xs        = x_ff >>> step_ff;
      ys        = y_ff >>> step_ff;
      ent       = $signed({1'b0, atan_entry(5'(step_ff))});
      z_round   = (z_ff + ROUND_HALF) >>> SHIFT;
   end

   // Sequencer.
   always_comb begin
      state_in = state_ff;
      sq_in    = sq_ff;
      rad_in   = rad_ff;
      rem_in   = rem_ff;
      root_in  = root_ff;
      rcnt_in  = rcnt_ff;
      x_in     = x_ff;
      y_in     = y_ff;
      z_in     = z_ff;
      step_in  = step_ff;
      zero_in  = zero_ff;
      done_in  = done_ff;
      angle_in = angle_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               done_in  = 1'b0;
               state_in = ST_SQA;
            end
         end
         ST_SQA: begin
            sq_in    = unsigned'(prod);
            state_in = ST_SQB;
         end
         ST_SQB: begin
            rad_in   = {sq_ff + unsigned'(prod), 16'h0000};
            rem_in   = '0;
            root_in  = '0;
            rcnt_in  = '0;
            state_in = ST_ROOT;
         end
         ST_ROOT: begin
            rem_in  = fits ? rem_diff[REMW-1:0] : rem_cat[REMW-1:0];
            root_in = root_next;
            rad_in  = rad_ff << 2;
            rcnt_in = rcnt_ff + 5'd1;
            if (rcnt_ff == LAST_ROOT) begin
               x_in     = XW'({1'b0, root_next});
               y_in     = XW'($signed({num, 8'h00}));
               z_in     = '0;
               step_in  = '0;
               zero_in  = (root_next == '0) && (num == '0);
               state_in = ST_ROT;
            end
         end
         ST_ROT: begin
            if (!y_ff[XW-1]) begin
               x_in = x_ff + ys;
               y_in = y_ff - xs;
               z_in = z_ff + ent;
            end else begin
               x_in = x_ff - ys;
               y_in = y_ff + xs;
               z_in = z_ff - ent;
            end
            step_in = step_ff + CW'(1);
            if (step_ff == LAST_STEP) begin
               state_in = ST_ROUND;
            end
         end
         ST_ROUND: begin
            angle_in = zero_ff ? '0 : z_round;
            done_in  = 1'b1;
            state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         done_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         done_ff  <= done_in;
      end
      sq_ff    <= sq_in;
      rad_ff   <= rad_in;
      rem_ff   <= rem_in;
      root_ff  <= root_in;
      rcnt_ff  <= rcnt_in;
      x_ff     <= x_in;
      y_ff     <= y_in;
      z_ff     <= z_in;
      step_ff  <= step_in;
      zero_ff  <= zero_in;
      angle_ff <= angle_in;
   end

   assign done  = done_ff;
   assign angle = angle_ff;

endmodule

// ----- rtl/imuc_rate.sv -----
// ---------------------------------------------------------------------------
// Gyro increment unit
// Computes raw * time_step / (131 * 2^(24 - ANGLE_FRAC_BITS)), rounded to
// nearest with ties away from zero, by a bit-serial division.
// ---------------------------------------------------------------------------
module imuc_rate #(
   parameter int ANGLE_FRAC_BITS = 16
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   input  logic signed [15:0] raw,
   input  logic [23:0]        step,
   output logic               done,
   output logic signed [33:0] delta
);
   import imuc_pkg::*;

   localparam int PW    = 41;
   localparam int DW    = 40;
   localparam int SHIFT = TAB_FRAC - ANGLE_FRAC_BITS;
   localparam logic [DW-1:0] HALF_DEN = DW'((GYRO_SCALE * (1 << SHIFT)) / 2);
   localparam logic [8:0]    DIVISOR  = 9'(GYRO_SCALE);
   localparam logic [5:0]    LAST_BIT = 6'(DW - 1);

   typedef enum logic [1:0] {ST_IDLE, ST_PREP, ST_DIV} state_type;

   state_type            state_ff, state_in;
   logic signed [PW-1:0] prod_ff, prod_in;
   logic [DW-1:0]        div_ff, div_in;
   logic [7:0]           rem_ff, rem_in;
   logic [5:0]           cnt_ff, cnt_in;
   logic                 neg_ff, neg_in;
   logic                 done_ff, done_in;
   logic signed [33:0]   delta_ff, delta_in;

   logic [PW-1:0]        mag;
   logic [DW-1:0]        biased;
   logic [8:0]           rem_cat, rem_sub;
   logic                 ge;
   logic [DW-1:0]        div_next;
   logic signed [33:0]   quot;

   // Magnitude with rounding bias, and one quotient bit per cycle.
   always_comb begin
      mag      = prod_ff[PW-1] ? unsigned'(-prod_ff) : unsigned'(prod_ff);
      biased   = (mag[DW-1:0] + HALF_DEN) >> SHIFT;
      rem_cat  = {rem_ff, div_ff[DW-1]};
      rem_sub  = rem_cat - DIVISOR;
      ge       = (rem_cat >= DIVISOR);
      div_next = {div_ff[DW-2:0], ge};
      quot     = $signed({1'b0, div_next[32:0]});
   end

   // Sequencer.
   always_comb begin
      state_in = state_ff;
      prod_in  = prod_ff;
      div_in   = div_ff;
      rem_in   = rem_ff;
      cnt_in   = cnt_ff;
      neg_in   = neg_ff;
      done_in  = done_ff;
      delta_in = delta_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               prod_in  = raw * $signed({1'b0, step});
               done_in  = 1'b0;
               state_in = ST_PREP;
            end
         end
         ST_PREP: begin
            div_in   = biased;
            neg_in   = prod_ff[PW-1];
            rem_in   = '0;
            cnt_in   = '0;
            state_in = ST_DIV;
         end
         ST_DIV: begin
            rem_in = ge ? rem_sub[7:0] : rem_cat[7:0];
            div_in = div_next;
            cnt_in = cnt_ff + 6'd1;
            if (cnt_ff == LAST_BIT) begin
               delta_in = neg_ff ? -quot : quot;
               done_in  = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         done_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         done_ff  <= done_in;
      end
      prod_ff  <= prod_in;
      div_ff   <= div_in;
      rem_ff   <= rem_in;
      cnt_ff   <= cnt_in;
      neg_ff   <= neg_in;
      delta_ff <= delta_in;
   end

   assign done  = done_ff;
   assign delta = delta_ff;

endmodule

// ----- tb/imu_attitude_checker.sv -----
// ---------------------------------------------------------------------------
// IMU attitude filter checker
// Watches the sample, result and register ports of the filter, keeps its own
// copy of the roll, pitch and yaw estimates and the registers, predicts each
// result in order and compares it field by field with what the filter sends.
// ---------------------------------------------------------------------------
module imu_attitude_checker (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   input  logic                              req_stall,
   input  imuc_pkg::imu_sample_type          req_data,
   input  logic                              rsp_valid,
   input  logic                              rsp_stall,
   input  imuc_pkg::attitude_type            rsp_data,
   input  logic                              csr_write,
   input  logic [imuc_pkg::CSR_INDEX_W-1:0]  csr_index,
   input  logic [23:0]                       csr_wdata,
   output int                                error_count,
   output int                                pending_count
);
   import imuc_pkg::*;

   localparam int ANGLE_FRAC = 16;
   localparam int ROTATIONS = 16;

   logic [16:0] weight;
   logic [23:0] step_q24;
   logic signed [31:0] roll_track, pitch_track, yaw_track;
   attitude_type attitude_q[$];

   assign pending_count = attitude_q.size();

   // Floor shift right of a signed value.
   function automatic longint floor_shift(input longint v, input int s);
      return v >>> s;
   endfunction

   function automatic longint int_sqrt(input longint unsigned n);
      longint unsigned r, b;
      r = 0;
      b = 64'd1 << 62;
      while (b > n) b = b >> 2;
      while (b != 0) begin
         if (n >= r + b) begin
            n = n - (r + b);
            r = (r >> 1) + b;
         end else begin
            r = r >> 1;
         end
         b = b >> 2;
      end
      return longint'(r);
   endfunction

   function automatic longint arctan_deg(input int i);
      longint t[16];
      t = '{754974720, 445687602, 235489088, 119537938, 60000934, 30029717,
            15018523, 7509720, 3754917, 1877466, 938734, 469367, 234684,
            117342, 58671, 29335};
      if (i < 16) return t[i];
      return (longint'(961263669) + (longint'(1) << (i - 1))) >>> i;
   endfunction

   // Tilt angle atan2(num, sqrt(a^2+b^2)) by vectoring rotations.
   function automatic longint tilt_angle(input longint num, input longint a,
                                         input longint b);
      longint x, y, z, xs, ys;
      longint unsigned sq;
      sq = longint'(a * a) + longint'(b * b);
      x = int_sqrt(sq << 16);
      y = num * 256;
      z = 0;
      if (x == 0 && y == 0) return 0;
      for (int i = 0; i < ROTATIONS; i++) begin
         xs = floor_shift(x, i);
         ys = floor_shift(y, i);
         if (y >= 0) begin
            x = x + ys; y = y - xs; z = z + arctan_deg(i);
         end else begin
            x = x - ys; y = y + xs; z = z - arctan_deg(i);
         end
      end
      return floor_shift(z + (longint'(1) << (24 - ANGLE_FRAC - 1)), 24 - ANGLE_FRAC);
   endfunction

   // Rate times interval, rounded with ties away from zero.
   function automatic longint rate_delta(input longint raw);
      longint den, p, m, q;
      den = longint'(131) << (24 - ANGLE_FRAC);
      p = raw * longint'(step_q24);
      m = p < 0 ? -p : p;
      q = (m + den / 2) / den;
      return p < 0 ? -q : q;
   endfunction

   function automatic longint clamp32(input longint v);
      if (v > 64'sd2147483647) return 64'sd2147483647;
      if (v < -64'sd2147483648) return -64'sd2147483648;
      return v;
   endfunction

   function automatic logic signed [31:0] mix(input logic signed [31:0] est,
                                              input longint delta,
                                              input longint acc);
      longint w, sum;
      w = weight > WEIGHT_ONE ? 65536 : longint'(weight);
      sum = w * (longint'(est) + delta) + (65536 - w) * acc;
      return 32'(clamp32(floor_shift(sum + 32768, 16)));
   endfunction

   // Advances the estimates by one sample and queues the expected attitude.
   task automatic update_attitude(input imu_sample_type s);
      longint ax, ay, az, yaw, half, full;
      attitude_type r;
      ax = s.accel_x; ay = s.accel_y; az = s.accel_z;
      half = longint'(180) << ANGLE_FRAC;
      full = longint'(360) << ANGLE_FRAC;
      roll_track = mix(roll_track, rate_delta(s.gyro_x), tilt_angle(ay, ax, az));
      pitch_track = mix(pitch_track, rate_delta(s.gyro_y), tilt_angle(-ax, ay, az));
      yaw = longint'(yaw_track) + rate_delta(s.gyro_z);
      if (yaw > half) yaw = yaw - full;
      if (yaw < -half) yaw = yaw + full;
      yaw_track = 32'(clamp32(yaw));
      r.roll_out = roll_track;
      r.pitch_out = pitch_track;
      r.yaw_out = yaw_track;
      attitude_q.push_back(r);
   endtask

   task automatic compare_field(input string name, input logic [31:0] exp_v,
                                input logic [31:0] act_v);
      if (exp_v !== act_v) begin
         $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name,
                  $signed(exp_v), $signed(act_v));
         error_count++;
      end
   endtask

   // Sample at each edge: registers, accepted items and accepted results.
   always @(posedge clock) begin
      attitude_type e;
      if (reset) begin
         weight <= BLEND_WEIGHT_RESET;
         step_q24 <= TIME_STEP_RESET;
         roll_track = 0; pitch_track = 0; yaw_track = 0;
         error_count = 0;
         attitude_q.delete();
      end else begin
         if (csr_write && csr_index == CSR_BLEND_WEIGHT) weight <= csr_wdata[16:0];
         if (csr_write && csr_index == CSR_TIME_STEP) step_q24 <= csr_wdata;
         if (rsp_valid && !rsp_stall) begin
            if (attitude_q.size() == 0) begin
               $display("%0t: unexpected result, expected none, actual %h", $time,
                        rsp_data);
               error_count++;
            end else begin
               e = attitude_q.pop_front();
               compare_field("roll_out", e.roll_out, rsp_data.roll_out);
               compare_field("pitch_out", e.pitch_out, rsp_data.pitch_out);
               compare_field("yaw_out", e.yaw_out, rsp_data.yaw_out);
            end
         end
         if (req_valid && !req_stall) update_attitude(req_data);
      end
   end

endmodule

// ----- tb/imu_complementary_attitude_filter_top_tb.sv -----
// ---------------------------------------------------------------------------
// IMU attitude filter testbench
// Drives directed and random sample items through the filter across several
// register settings, with bursty input and a stalling output, and reports the
// verdict from the checker's error count.
// ---------------------------------------------------------------------------
module imu_complementary_attitude_filter_top_tb;
   import imuc_pkg::*;

   logic clock;
   logic reset;
   logic req_valid;
   logic req_stall;
   imu_sample_type req_data;
   logic rsp_valid;
   logic rsp_stall;
   attitude_type rsp_data;
   logic csr_write;
   logic [CSR_INDEX_W-1:0] csr_index;
   logic [23:0] csr_wdata;
   int error_count;
   int pending_count;
   bit hold_off;

   imu_complementary_attitude_filter_top dut (.*);

   imu_attitude_checker checker_i (.*);

   initial begin
      clock = 0;
      forever #6 clock = ~clock;
   end

   // The run ends here if the block hangs.
   initial begin
      #40000000;
      $display("imu_complementary_attitude_filter_top_tb: done, errors");
      $finish;
   end

   function automatic logic [15:0] rand_axis();
      case ($urandom_range(0, 5))
         0: return 16'h8000;
         1: return 16'h7fff;
         2: return 16'(int'($urandom_range(0, 40)) - 20);
         default: return 16'($urandom);
      endcase
   endfunction

   // Offers one item and holds it until accepted.
   task automatic send_sample(input imu_sample_type s);
      req_valid <= 1'b1;
      req_data <= s;
      @(posedge clock);
      while (req_stall) @(posedge clock);
   endtask

   task automatic idle_gap(input int n);
      req_valid <= 1'b0;
      repeat (n) @(posedge clock);
   endtask

   // One register write; the write strobe is then dropped before anything else is driven.
   task automatic write_reg(input logic [CSR_INDEX_W-1:0] idx, input logic [23:0] v);
      csr_write <= 1'b1;
      csr_index <= idx;
      csr_wdata <= v;
      @(posedge clock);
      csr_write <= 1'b0;
      @(posedge clock);
   endtask

   // Waits for all results, then lets the clock run on with no input.
   task automatic drain();
      req_valid <= 1'b0;
      while (pending_count != 0) @(posedge clock);
      repeat (100) @(posedge clock);
   endtask

   task automatic random_phase(input int n);
      imu_sample_type s;
      int burst;
      burst = 0;
      for (int i = 0; i < n; i++) begin
         if (burst == 0) begin
            burst = $urandom_range(1, 12);
            if ($urandom_range(0, 2) != 0) idle_gap($urandom_range(1, 150));
         end
         burst--;
         s = {rand_axis(), rand_axis(), rand_axis(), rand_axis(), rand_axis(),
              rand_axis()};
         send_sample(s);
      end
   endtask

   // Receiver stall pattern, with one long hold-off on request.
   initial begin
      rsp_stall = 1'b0;
      forever begin
         @(posedge clock);
         if (hold_off) begin
            rsp_stall <= 1'b1;
            repeat (600) @(posedge clock);
            hold_off = 0;
         end else if ($urandom_range(0, 3) == 0) begin
            rsp_stall <= 1'b1;
            repeat ($urandom_range(1, 90)) @(posedge clock);
         end
         rsp_stall <= 1'b0;
         repeat ($urandom_range(0, 60)) @(posedge clock);
      end
   end

   initial begin
      imu_sample_type d[$];
      logic [16:0] w_set[6];
      logic [23:0] t_set[6];
      hold_off = 0;
      reset = 1'b1;
      req_valid = 1'b0;
      req_data = '0;
      csr_write = 1'b0;
      csr_index = CSR_BLEND_WEIGHT;
      csr_wdata = '0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed items at reset settings: zero vector, extremes, each accelerometer axis.
      d.push_back('0);
      d.push_back({16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff});
      d.push_back({16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h8000});
      d.push_back({16'h8000, 16'h0, 16'h0, 16'h0, 16'h0, 16'h0});
      d.push_back({16'h0, 16'h7fff, 16'h0, 16'h0, 16'h0, 16'h0});
      d.push_back({16'h0, 16'h8000, 16'h0, 16'h0, 16'h0, 16'h0});
      d.push_back({16'h0, 16'h0, 16'h4000, 16'h0, 16'h0, 16'h0});
      d.push_back({16'h0, 16'h0, 16'hc000, 16'h0, 16'h0, 16'h0});
      d.push_back({16'h1, 16'hffff, 16'h1, 16'h83, 16'hff7d, 16'h1});
      d.push_back({16'h5555, 16'haaaa, 16'h5555, 16'haaaa, 16'h5555, 16'haaaa});
      d.push_back({16'haaaa, 16'h5555, 16'haaaa, 16'h5555, 16'haaaa, 16'h5555});
      foreach (d[i]) send_sample(d[i]);
      drain();

      // Large step and gyro extremes drive the yaw wrap both ways.
      write_reg(CSR_TIME_STEP, 24'hffffff);
      write_reg(CSR_BLEND_WEIGHT, 17'h1ffff);
      for (int i = 0; i < 6; i++) send_sample({48'h0, 16'h7fff, 16'h7fff, 16'h7fff});
      for (int i = 0; i < 8; i++) send_sample({48'h0, 16'h8000, 16'h8000, 16'h8000});
      drain();

      // Random phases over several settings; the hold-off fills the block.
      w_set = '{17'd0, 17'd65536, 17'd65537, 17'd64225, 17'd1, 17'd32768};
      t_set = '{24'd0, 24'hffffff, 24'd335544, 24'd1, 24'd4000000, 24'd335544};
      for (int p = 0; p < 6; p++) begin
         write_reg(CSR_BLEND_WEIGHT, w_set[p]);
         write_reg(CSR_TIME_STEP, t_set[p]);
         if ($urandom_range(0, 1) != 0) write_reg(8'd2 + 8'(p), 24'($urandom));
         if (p == 2) hold_off = 1;
         random_phase(155);
         drain();
      end

      if (error_count == 0) begin
         $display("imu_complementary_attitude_filter_top_tb: done, clean");
      end else begin
         $display("imu_complementary_attitude_filter_top_tb: done, errors");
      end
      $finish;
   end
endmodule
